// ===== rtl/core/sbec_pkg.sv =====
// ----------------------------------------------------------------------------
// sbec_pkg
// Shared codes for the sphere boundary exceed check: register indexes and
// axis codes.
// ----------------------------------------------------------------------------
package sbec_pkg;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_CENTER_Z    = 3'd2,
        REG_RADIUS      = 3'd3,
        REG_PLANAR_MODE = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

endpackage

// ===== rtl/core/sbec_point_if.sv =====
// ----------------------------------------------------------------------------
// sbec_point_if
// Point channel: valid/ready with three signed coordinates.
// ----------------------------------------------------------------------------
interface sbec_point_if #(
    parameter int W = 31
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// ===== rtl/core/sbec_result_if.sv =====
// ----------------------------------------------------------------------------
// sbec_result_if
// Result channel: valid/ready with exceed flag, axis and coordinates.
// ----------------------------------------------------------------------------
interface sbec_result_if #(
    parameter int W = 31
);
    logic                valid;
    logic                ready;
    logic                exceeded;
    logic [1:0]          axis;
    logic signed [W-1:0] axis_value;
    logic signed [W:0]   boundary_value;

    modport source (output valid, exceeded, axis, axis_value, boundary_value,
                    input ready);
    modport sink   (input valid, exceeded, axis, axis_value, boundary_value,
                    output ready);
endinterface

// ===== rtl/core/sbec_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sbec_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sbec_cfg_if #(
    parameter int W = 31
);
    logic         valid;
    logic         ready;
    logic [2:0]   index;
    logic [W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sbec_front.sv =====
// ----------------------------------------------------------------------------
// sbec_front
// Five-stage front end: offsets, magnitudes, squares and axis pick,
// sum of squares and radius product, outside test.
// ----------------------------------------------------------------------------
module sbec_front
    import sbec_pkg::*;
#(
    parameter int C  = 31,
    parameter int TW = 96
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [C-1:0]   px,
    input  logic signed [C-1:0]   py,
    input  logic signed [C-1:0]   pz,
    input  logic signed [C-1:0]   cx,
    input  logic signed [C-1:0]   cy,
    input  logic signed [C-1:0]   cz,
    input  logic [C-2:0]          radius,
    input  logic                  planar,
    input  logic [2*C-3:0]        r2,
    output logic                  out_valid,
    output logic [2*C+1:0]        out_sum,
    output logic [TW-1:0]         out_tag
);
    localparam int SW = 2*C + 2;
    localparam int PW = 2*C - 1;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [C:0]   d_reg [3];
    logic signed [C-1:0] p1_reg [3];
    logic [C-1:0]        a_reg [3];
    logic [2:0]          s2_reg;
    logic signed [C-1:0] p2_reg [3];
    logic [2*C-1:0]      sq_reg [3];
    axis_t               axis3_reg, axis3_next, axis4_reg, axis5_reg;
    logic                sign3_reg, sign4_reg, sign5_reg;
    logic signed [C-1:0] pa3_reg, pa4_reg, pa5_reg;
    logic [C-1:0]        aa3_reg;
    logic [SW-1:0]       sum4_reg, sum5_reg;
    logic [PW-1:0]       prod4_reg, prod5_reg;
    logic                exc5_reg;

    always_comb
    begin
        if (a_reg[0] > a_reg[1])
            axis3_next = (a_reg[0] > a_reg[2]) ? AXIS_X : AXIS_Z;
        else
            axis3_next = (a_reg[1] > a_reg[2]) ? AXIS_Y : AXIS_Z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: offsets from the centre
            d_reg[0]  <= (C+1)'($signed({px[C-1], px}) - $signed({cx[C-1], cx}));
            d_reg[1]  <= planar ? '0 :
                         (C+1)'($signed({py[C-1], py}) - $signed({cy[C-1], cy}));
            d_reg[2]  <= (C+1)'($signed({pz[C-1], pz}) - $signed({cz[C-1], cz}));
            p1_reg[0] <= px;
            p1_reg[1] <= py;
            p1_reg[2] <= pz;
            // stage 2: magnitudes (offset always fits C bits)
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i]  <= d_reg[i][C] ? C'(-d_reg[i]) : C'(d_reg[i]);
                s2_reg[i] <= d_reg[i][C];
                p2_reg[i] <= p1_reg[i];
            end
            // stage 3: squares and dominant axis
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= a_reg[i] * a_reg[i];
            axis3_reg <= axis3_next;
            sign3_reg <= s2_reg[axis3_next];
            pa3_reg   <= p2_reg[axis3_next];
            aa3_reg   <= a_reg[axis3_next];
            // stage 4: sum of squares, numerator of the ratio
            sum4_reg  <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            prod4_reg <= radius * aa3_reg;
            axis4_reg <= axis3_reg;
            sign4_reg <= sign3_reg;
            pa4_reg   <= pa3_reg;
            // stage 5: strictly outside test
            exc5_reg  <= sum4_reg > SW'(r2);
            sum5_reg  <= sum4_reg;
            prod5_reg <= prod4_reg;
            axis5_reg <= axis4_reg;
            sign5_reg <= sign4_reg;
            pa5_reg   <= pa4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_sum   = sum5_reg;
    assign out_tag   = {exc5_reg, axis5_reg, sign5_reg, pa5_reg, prod5_reg};

endmodule

// ===== rtl/core/sbec_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// sbec_sqrt_cell
// One digit of the bit-by-bit integer square root, registered.
// ----------------------------------------------------------------------------
module sbec_sqrt_cell #(
    parameter int RW  = 32,
    parameter int IDX = 0,
    parameter int TW  = 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   in_n,
    input  logic [2*RW-1:0]   in_r,
    input  logic [TW-1:0]     in_tag,
    output logic              out_valid,
    output logic [2*RW-1:0]   out_n,
    output logic [2*RW-1:0]   out_r,
    output logic [TW-1:0]     out_tag
);
    localparam int SW = 2*RW;
    localparam int BP = 2*(RW - 1 - IDX);

    logic [SW-1:0] bit_val;
    logic [SW-1:0] trial;
    logic          take;
    logic          valid_reg;
    logic [SW-1:0] n_reg, r_reg;
    logic [TW-1:0] tag_reg;

    assign bit_val = SW'(1) << BP;
    assign trial   = in_r + bit_val;
    assign take    = in_n >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= take ? in_n - trial : in_n;
            r_reg   <= take ? (in_r >> 1) + bit_val : in_r >> 1;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_r     = r_reg;
    assign out_tag   = tag_reg;

endmodule

// ===== rtl/core/sbec_div_cell.sv =====
// ----------------------------------------------------------------------------
// sbec_div_cell
// One quotient bit of a restoring divider, registered.
// ----------------------------------------------------------------------------
module sbec_div_cell #(
    parameter int PW  = 61,
    parameter int RW  = 32,
    parameter int QW  = 30,
    parameter int IDX = 0,
    parameter int TW  = 1
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [PW-1:0]     in_rem,
    input  logic [RW-1:0]     in_div,
    input  logic [QW-1:0]     in_q,
    input  logic [TW-1:0]     in_tag,
    output logic              out_valid,
    output logic [PW-1:0]     out_rem,
    output logic [RW-1:0]     out_div,
    output logic [QW-1:0]     out_q,
    output logic [TW-1:0]     out_tag
);
    localparam int K = QW - 1 - IDX;

    logic [PW-1:0] shifted;
    logic          take;
    logic          valid_reg;
    logic [PW-1:0] rem_reg;
    logic [RW-1:0] div_reg;
    logic [QW-1:0] q_reg;
    logic [TW-1:0] tag_reg;

    assign shifted = PW'(in_div) << K;
    assign take    = in_rem >= shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= take ? in_rem - shifted : in_rem;
            div_reg <= in_div;
            q_reg   <= take ? in_q | (QW'(1) << K) : in_q;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_q     = q_reg;
    assign out_tag   = tag_reg;

endmodule

// ===== rtl/core/sphere_boundary_exceed_check_core.sv =====
// ----------------------------------------------------------------------------
// sphere_boundary_exceed_check_core
// Tests points against a sphere (or x-z circle) and projects outside points
// radially onto the boundary along the dominant axis.
// ----------------------------------------------------------------------------
// Pipeline: 5 front stages, one square root cell per root bit, one divider
//   cell per quotient bit, then the output register.
// Throughput: one point per cycle; the whole chain advances together and
//   holds only while a result sits in the output register untaken.
// Reset: asynchronous, clears all valids and the configuration to zero.
module sphere_boundary_exceed_check_core
    import sbec_pkg::*;
#(
    parameter int COORD_BITS = 31
)(
    input  logic          clk,
    input  logic          rst_n,
    sbec_point_if.sink    pt,
    sbec_result_if.source res,
    sbec_cfg_if.sink      cfg
);
    localparam int C  = COORD_BITS;
    localparam int RW = C + 1;
    localparam int SW = 2*RW;
    localparam int PW = 2*C - 1;
    localparam int QW = C - 1;
    localparam int DTW = C + 4;
    localparam int STW = DTW + PW;

    logic signed [C-1:0] cx_reg, cy_reg, cz_reg;
    logic [C-2:0]        radius_reg;
    logic                planar_reg;
    logic [2*C-3:0]      r2_reg;
    logic                en;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            radius_reg <= '0;
            planar_reg <= 1'b0;
            r2_reg     <= '0;
        end
        else
        begin
            r2_reg <= radius_reg * radius_reg;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_CENTER_X:    cx_reg     <= cfg.data;
                    REG_CENTER_Y:    cy_reg     <= cfg.data;
                    REG_CENTER_Z:    cz_reg     <= cfg.data;
                    REG_RADIUS:      radius_reg <= cfg.data[C-2:0];
                    REG_PLANAR_MODE: planar_reg <= cfg.data[0];
                    default:         ;
                endcase
            end
        end
    end

    // chain
    logic              out_valid_reg;
    assign en       = !out_valid_reg || res.ready;
    assign pt.ready = en;

    logic              sq_v   [RW+1];
    logic [SW-1:0]     sq_n   [RW+1];
    logic [SW-1:0]     sq_r   [RW+1];
    logic [STW-1:0]    sq_tag [RW+1];

    sbec_front #(.C(C), .TW(STW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pt.valid),
        .px       (pt.point_x),
        .py       (pt.point_y),
        .pz       (pt.point_z),
        .cx       (cx_reg),
        .cy       (cy_reg),
        .cz       (cz_reg),
        .radius   (radius_reg),
        .planar   (planar_reg),
        .r2       (r2_reg),
        .out_valid(sq_v[0]),
        .out_sum  (sq_n[0]),
        .out_tag  (sq_tag[0])
    );
    assign sq_r[0] = '0;

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        sbec_sqrt_cell #(.RW(RW), .IDX(k), .TW(STW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (sq_v[k]),
            .in_n     (sq_n[k]),
            .in_r     (sq_r[k]),
            .in_tag   (sq_tag[k]),
            .out_valid(sq_v[k+1]),
            .out_n    (sq_n[k+1]),
            .out_r    (sq_r[k+1]),
            .out_tag  (sq_tag[k+1])
        );
    end

    logic              dv_v   [QW+1];
    logic [PW-1:0]     dv_rem [QW+1];
    logic [RW-1:0]     dv_div [QW+1];
    logic [QW-1:0]     dv_q   [QW+1];
    logic [DTW-1:0]    dv_tag [QW+1];

    assign dv_v[0]   = sq_v[RW];
    assign dv_rem[0] = sq_tag[RW][PW-1:0];
    assign dv_div[0] = sq_r[RW][RW-1:0];
    assign dv_q[0]   = '0;
    assign dv_tag[0] = sq_tag[RW][STW-1:PW];

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        sbec_div_cell #(.PW(PW), .RW(RW), .QW(QW), .IDX(k), .TW(DTW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (dv_v[k]),
            .in_rem   (dv_rem[k]),
            .in_div   (dv_div[k]),
            .in_q     (dv_q[k]),
            .in_tag   (dv_tag[k]),
            .out_valid(dv_v[k+1]),
            .out_rem  (dv_rem[k+1]),
            .out_div  (dv_div[k+1]),
            .out_q    (dv_q[k+1]),
            .out_tag  (dv_tag[k+1])
        );
    end

    // output stage
    logic                f_exc, f_sign;
    axis_t               f_axis;
    logic signed [C-1:0] f_pa, f_c;
    logic signed [C:0]   f_q, f_bound;
    logic                exc_reg;
    logic [1:0]          axis_reg;
    logic signed [C-1:0] av_reg;
    logic signed [C:0]   bv_reg;

    assign f_exc  = dv_tag[QW][DTW-1];
    assign f_axis = axis_t'(dv_tag[QW][DTW-2:DTW-3]);
    assign f_sign = dv_tag[QW][C];
    assign f_pa   = dv_tag[QW][C-1:0];
    assign f_q    = $signed({2'b00, dv_q[QW]});

    always_comb
    begin
        case (f_axis)
            AXIS_X:  f_c = cx_reg;
            AXIS_Y:  f_c = cy_reg;
            default: f_c = cz_reg;
        endcase
        f_bound = $signed({f_c[C-1], f_c}) + (f_sign ? -f_q : f_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_v[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            exc_reg  <= f_exc;
            axis_reg <= f_exc ? f_axis : AXIS_X;
            av_reg   <= f_exc ? f_pa : '0;
            bv_reg   <= f_exc ? f_bound : '0;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.exceeded       = exc_reg;
    assign res.axis           = axis_reg;
    assign res.axis_value     = av_reg;
    assign res.boundary_value = bv_reg;

endmodule

// ===== rtl/core/sbec_checker.sv =====
// ----------------------------------------------------------------------------
// sbec_checker
// Port-level checks on the sphere boundary exceed check, bound to the top.
// ----------------------------------------------------------------------------
module sbec_checker
    import sbec_pkg::*;
#(
    parameter int COORD_BITS = 31
)(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         pt_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         exceeded,
    input logic [1:0]                   axis,
    input logic signed [COORD_BITS-1:0] axis_value,
    input logic signed [COORD_BITS:0]   boundary_value
);
    // input side moves exactly when the output register can drain
    assert property (@(posedge clk) disable iff (!rst_n)
        pt_ready == (!res_valid || res_ready))
        else $error("point ready does not track output drain");

    // a not-exceeded transaction carries zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !exceeded |->
            axis == AXIS_X && axis_value == '0 && boundary_value == '0)
        else $error("non-exceeded result with non-zero fields");

    // the axis code is never the unused one
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> axis == AXIS_X || axis == AXIS_Y || axis == AXIS_Z)
        else $error("illegal axis code");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(exceeded)
            && $stable(axis) && $stable(axis_value) && $stable(boundary_value))
        else $error("stalled result changed");

endmodule

bind sphere_boundary_exceed_check_core sbec_checker #(.COORD_BITS(COORD_BITS)) u_sbec_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .pt_ready      (pt.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .exceeded      (res.exceeded),
    .axis          (res.axis),
    .axis_value    (res.axis_value),
    .boundary_value(res.boundary_value)
);
